// ===== hdl/tpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_TEMP     = 2'd0;
	localparam logic [1:0] REG_PRES_LO  = 2'd1;
	localparam logic [1:0] REG_PRES_HI  = 2'd2;
	localparam logic [1:0] REG_PRES_NINE = 2'd3;

	// One pressure job passed from the front part to the back part.
	typedef struct packed {
		logic [31:0] temp;     // finished temperature in 0.01 degC
		logic [31:0] scaled;   // scaled pressure numerator before the divide
		logic [31:0] divisor;  // pressure divisor, zero means no pressure
	} tpc_item_t;

	// Queue occupancy flags seen by both neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} tpc_qstat_t;

	// Low 32 bits of a product, which is the same for signed and unsigned operands.
	function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] full_prod;
		full_prod = {32'd0, a} * {32'd0, b};
		return full_prod[31:0];
	endfunction

	// Signed divide by two to the k, truncating toward zero.
	function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input int unsigned k);
		logic [31:0] mask;
		logic [31:0] sum;
		mask = (32'd1 << k) - 32'd1;
		sum = x + (x[31] ? mask : 32'd0);
		return 32'($signed(sum) >>> k);
	endfunction

	// Sign extension of a 16-bit coefficient.
	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tpc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [47:0]      temp_coef,
	input  wire logic [63:0]      pres_lo,
	input  wire logic [63:0]      pres_hi,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [19:0]      raw_temperature,
	input  wire logic [19:0]      raw_pressure,
	input  wire tpc_pkg::tpc_qstat_t qstat,
	output logic                  push,
	output tpc_pkg::tpc_item_t    push_item
);
	import tpc_pkg::*;

	localparam int NSTAGE = 11;

	logic [NSTAGE-1:0] vld_q;
	logic advance;

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;

	logic [31:0] a0_s1, b0_s1, adcp_s1;
	logic [31:0] m1_s2, bb_s2, adcp_s2;
	logic [31:0] a_s3, m2_s3, adcp_s3;
	logic [31:0] fine_s4, adcp_s4;
	logic [31:0] temp_s5, pa_s5, adcp_s5;
	logic [31:0] sq_s6, ap5_s6, p2a_s6, temp_s6, adcp_s6;
	logic [31:0] b1_s7, c_s7, d_s7, ap5x2_s7, temp_s7, adcp_s7;
	logic [31:0] b_s8, ad_s8, temp_s8, adcp_s8;
	logic [31:0] m_s9, b_s9, temp_s9, adcp_s9;
	logic [31:0] div_s10, diff_s10, temp_s10;
	logic [31:0] p_s11, div_s11, temp_s11;

	// Coefficient slices.
	assign t1 = {16'd0, temp_coef[15:0]};
	assign t2 = sx16(temp_coef[31:16]);
	assign t3 = sx16(temp_coef[47:32]);
	assign p1 = {16'd0, pres_lo[15:0]};
	assign p2 = sx16(pres_lo[31:16]);
	assign p3 = sx16(pres_lo[47:32]);
	assign p4 = sx16(pres_lo[63:48]);
	assign p5 = sx16(pres_hi[15:0]);
	assign p6 = sx16(pres_hi[31:16]);

	// The pipeline moves as a whole unless its last stage is blocked by a full queue.
	assign push = vld_q[NSTAGE-1] && !qstat.full;
	assign advance = !vld_q[NSTAGE-1] || !qstat.full;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	// Datapath stages, one multiply deep each.
	always_ff @(posedge clk) begin
		if (advance) begin
			a0_s1   <= ({12'd0, raw_temperature} >> 3) - (t1 << 1);
			b0_s1   <= ({12'd0, raw_temperature} >> 4) - t1;
			adcp_s1 <= {12'd0, raw_pressure};

			m1_s2   <= mul_lo(a0_s1, t2);
			bb_s2   <= mul_lo(b0_s1, b0_s1);
			adcp_s2 <= adcp_s1;

			a_s3    <= sdiv_p2(m1_s2, 11);
			m2_s3   <= mul_lo(sdiv_p2(bb_s2, 12), t3);
			adcp_s3 <= adcp_s2;

			fine_s4 <= a_s3 + sdiv_p2(m2_s3, 14);
			adcp_s4 <= adcp_s3;

			temp_s5 <= sdiv_p2(mul_lo(fine_s4, 32'd5) + 32'd128, 8);
			pa_s5   <= sdiv_p2(fine_s4, 1) - 32'd64000;
			adcp_s5 <= adcp_s4;

			sq_s6   <= mul_lo(sdiv_p2(pa_s5, 2), sdiv_p2(pa_s5, 2));
			ap5_s6  <= mul_lo(pa_s5, p5);
			p2a_s6  <= mul_lo(p2, pa_s5);
			temp_s6 <= temp_s5;
			adcp_s6 <= adcp_s5;

			b1_s7    <= mul_lo(sdiv_p2(sq_s6, 11), p6);
			c_s7     <= mul_lo(p3, sdiv_p2(sq_s6, 13));
			d_s7     <= sdiv_p2(p2a_s6, 1);
			ap5x2_s7 <= ap5_s6 << 1;
			temp_s7  <= temp_s6;
			adcp_s7  <= adcp_s6;

			b_s8    <= sdiv_p2(b1_s7 + ap5x2_s7, 2) + (p4 << 16);
			ad_s8   <= sdiv_p2(sdiv_p2(c_s7, 3) + d_s7, 18);
			temp_s8 <= temp_s7;
			adcp_s8 <= adcp_s7;

			m_s9    <= mul_lo(32'd32768 + ad_s8, p1);
			b_s9    <= b_s8;
			temp_s9 <= temp_s8;
			adcp_s9 <= adcp_s8;

			div_s10  <= sdiv_p2(m_s9, 15);
			diff_s10 <= (32'd1048576 - adcp_s9) - sdiv_p2(b_s9, 12);
			temp_s10 <= temp_s9;

			p_s11    <= mul_lo(diff_s10, 32'd3125);
			div_s11  <= div_s10;
			temp_s11 <= temp_s10;
		end
	end

	assign push_item = '{temp: temp_s11, scaled: p_s11, divisor: div_s11};

endmodule

`default_nettype wire

// ===== hdl/tpc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tpc_pkg::tpc_item_t push_item,
	input  wire logic               pop,
	output tpc_pkg::tpc_item_t      head,
	output tpc_pkg::tpc_qstat_t     qstat
);
	import tpc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tpc_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tpc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [63:0]        pres_hi,
	input  wire logic [15:0]        pres_nine,
	input  wire tpc_pkg::tpc_item_t head,
	input  wire tpc_pkg::tpc_qstat_t qstat,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             temperature_centi,
	output logic [31:0]             pressure_pascal,
	output logic                    pressure_valid
);
	import tpc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_POST1 = 3'd2;
	localparam logic [2:0] ST_POST2 = 3'd3;
	localparam logic [2:0] ST_POST3 = 3'd4;

	logic [2:0]  state_q;
	logic [2:0]  step_q;
	logic [32:0] rem_q;
	logic [31:0] num_q, quo_q, div_q, temp_q;
	logic        dbl_q, nz_q;
	logic [31:0] p_q, sq8_q, dm_q, cm_q;
	logic [31:0] p7, p8, p9;
	logic [32:0] rem_n;
	logic [31:0] num_n, quo_n;
	logic [31:0] pres_sum;
	logic        slot_free;
	logic        load_out;

	assign p7 = sx16(pres_hi[47:32]);
	assign p8 = sx16(pres_hi[63:48]);
	assign p9 = sx16(pres_nine);

	assign slot_free = !out_valid || out_ready;
	assign load_out = (state_q == ST_POST3) && slot_free;
	assign pop = (state_q == ST_IDLE) && !qstat.empty;

	// Four restoring division steps per cycle.
	always_comb begin
		rem_n = rem_q;
		num_n = num_q;
		quo_n = quo_q;
		for (int i = 0; i < 4; i++) begin
			rem_n = {rem_n[31:0], num_n[31]};
			num_n = num_n << 1;
			if (rem_n >= {1'b0, div_q}) begin
				rem_n = rem_n - {1'b0, div_q};
				quo_n = {quo_n[30:0], 1'b1};
			end else begin
				quo_n = {quo_n[30:0], 1'b0};
			end
		end
	end

	// Final correction of the pressure.
	assign pres_sum = p_q + sdiv_p2(sdiv_p2(cm_q, 12) + sdiv_p2(dm_q, 13) + p7, 4);

	// Output valid flag: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Sequencer for divide and correction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd7) begin
						state_q <= ST_POST1;
					end
				end
				ST_POST1: state_q <= ST_POST2;
				ST_POST2: state_q <= ST_POST3;
				ST_POST3: begin
					if (slot_free) begin
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					temp_q <= head.temp;
					div_q  <= head.divisor;
					nz_q   <= (head.divisor != 32'd0);
					dbl_q  <= head.scaled[31];
					num_q  <= head.scaled[31] ? head.scaled : (head.scaled << 1);
					rem_q  <= '0;
					quo_q  <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= rem_n;
				num_q <= num_n;
				quo_q <= quo_n;
				if (step_q == 3'd7) begin
					p_q <= dbl_q ? (quo_n << 1) : quo_n;
				end
			end
			ST_POST1: begin
				sq8_q <= mul_lo(p_q >> 3, p_q >> 3);
				dm_q  <= mul_lo(p_q >> 2, p8);
			end
			ST_POST2: begin
				cm_q <= mul_lo(p9, sq8_q >> 13);
			end
			ST_POST3: begin
				if (slot_free) begin
					temperature_centi <= temp_q;
					pressure_pascal   <= nz_q ? pres_sum : 32'd0;
					pressure_valid    <= nz_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/temp_pressure_compensation_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Temperature and pressure compensation unit.
// Input channel (in_valid/in_ready) carries one raw temperature and one raw
// pressure reading per transaction. Output channel (out_valid/out_ready)
// returns temperature in 0.01 degC, pressure in pascals and pressure_valid,
// which is low with pressure_pascal zero when the pressure divisor is zero.
// Calibration registers are written through cfg_write_enable, cfg_index and
// cfg_data; the user must write them only while the unit is idle, which the
// block does not enforce. All of them reset to zero. An 11-stage front
// pipeline accepts one transaction per cycle unless stalled by a full queue,
// and feeds a small queue. The back part takes one job at a time: the
// divider (four quotient bits per cycle), the correction states POST1 and
// POST2, then POST3 loads the output register. When the receiver stalls,
// the result holds in the output register, the back part waits, the queue
// fills and then the front pipeline stops and drops in_ready. Reset clears
// all valid flags, the queue counters, the sequencer state and the
// calibration registers.
module temp_pressure_compensation_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_enable,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      temperature_centi,
	output logic [31:0]      pressure_pascal,
	output logic             pressure_valid
);
	import tpc_pkg::*;

	logic [47:0] temp_coef_q;
	logic [63:0] pres_lo_q, pres_hi_q;
	logic [15:0] pres_nine_q;
	tpc_item_t   push_item, head;
	tpc_qstat_t  qstat;
	logic        push, pop;

	// Calibration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coef_q <= '0;
			pres_lo_q   <= '0;
			pres_hi_q   <= '0;
			pres_nine_q <= '0;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				REG_TEMP:      temp_coef_q <= cfg_data[47:0];
				REG_PRES_LO:   pres_lo_q   <= cfg_data;
				REG_PRES_HI:   pres_hi_q   <= cfg_data;
				REG_PRES_NINE: pres_nine_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	tpc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.temp_coef(temp_coef_q), .pres_lo(pres_lo_q), .pres_hi(pres_hi_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.qstat(qstat), .push(push), .push_item(push_item)
	);

	tpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item),
		.pop(pop), .head(head), .qstat(qstat)
	);

	tpc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pres_hi(pres_hi_q), .pres_nine(pres_nine_q),
		.head(head), .qstat(qstat), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.temperature_centi(temperature_centi),
		.pressure_pascal(pressure_pascal),
		.pressure_valid(pressure_valid)
	);

`ifndef NO_ASSERTIONS
	// The front never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("queue overflow");

	// The back never reads an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("queue underflow");

	// A result without pressure carries zero pressure.
	a_zero_pres: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pressure_valid) |-> (pressure_pascal == 32'd0))
		else $error("invalid pressure not zero");
`endif

endmodule

`default_nettype wire
